@@ src/planar_16colour_pixel_engine_top_defines.svh @@
// Assertion helpers for the pixel engine.
`ifndef PLANAR_16COLOUR_PIXEL_ENGINE_TOP_DEFINES_SVH
`define PLANAR_16COLOUR_PIXEL_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define PE16_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define PE16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pe16_pkg.sv @@
package pe16_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 1024;
   localparam int MAX_HEIGHT_DEFAULT  = 512;
   localparam int STORE_WORDS_DEFAULT = (MAX_WIDTH_DEFAULT / 8) * MAX_HEIGHT_DEFAULT;

   localparam int NUM_PLANES  = 4;
   localparam int PLANE_BITS  = 8;
   localparam int WORD_W      = NUM_PLANES * PLANE_BITS;
   localparam int PLANE_SEL_W = $clog2(NUM_PLANES);
   localparam int BIT_SEL_W   = $clog2(PLANE_BITS);

   localparam int POS_X_W      = 10;
   localparam int POS_Y_W      = 9;
   localparam int COLOUR_IN_W  = 32;
   localparam int ROWS_W       = 10;
   localparam int FILL_W       = NUM_PLANES;
   localparam int COLOUR_OUT_W = 24;

   localparam int SCREEN_W_W = 11;
   localparam int SCREEN_H_W = 10;
   localparam int CSR_DATA_W = SCREEN_W_W;
   localparam int BPR_W      = SCREEN_W_W - BIT_SEL_W;

   localparam logic [SCREEN_W_W-1:0] SCREEN_W_RESET = 11'd720;
   localparam logic [SCREEN_H_W-1:0] SCREEN_H_RESET = 10'd480;

   typedef enum logic [1:0] {
      ACT_SET    = 2'd0,
      ACT_GET    = 2'd1,
      ACT_SCROLL = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_LOOK,
      ST_MODIFY,
      ST_SETUP,
      ST_COPY,
      ST_FILL
   } seq_state_type;

   typedef struct packed {
      action_type              action;
      logic [POS_X_W-1:0]      pos_x;
      logic [POS_Y_W-1:0]      pos_y;
      logic [COLOUR_IN_W-1:0]  colour_in;
      logic [ROWS_W-1:0]       scroll_rows;
      logic [FILL_W-1:0]       fill_index;
   } req_payload_type;

   typedef struct packed {
      logic [COLOUR_OUT_W-1:0] colour_out;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type           index;
      logic [CSR_DATA_W-1:0]   data;
   } csr_payload_type;

   typedef struct packed {
      logic                    live;
      logic [SCREEN_W_W-1:0]   width;
      logic [SCREEN_H_W-1:0]   height;
      logic [BPR_W-1:0]        bytes_per_row;
   } geom_type;

endpackage

@@ src/pe16_chan_if.sv @@
interface pe16_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

@@ src/pe16_store.sv @@
module pe16_store #(
   parameter int  DEPTH  = pe16_pkg::STORE_WORDS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [pe16_pkg::WORD_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [pe16_pkg::WORD_W-1:0] rd_data
);
   import pe16_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pe16_cfg.sv @@
module pe16_cfg #(
   parameter int MAX_WIDTH  = pe16_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pe16_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pe16_chan_if.sink          csr_if,
   output pe16_pkg::geom_type geom
);
   import pe16_pkg::*;

   localparam int WL_W = SCREEN_W_W + 1;
   localparam int HL_W = SCREEN_H_W + 1;
   localparam logic [WL_W-1:0] WIDTH_LIMIT  = WL_W'(MAX_WIDTH);
   localparam logic [HL_W-1:0] HEIGHT_LIMIT = HL_W'(MAX_HEIGHT);

   logic [SCREEN_W_W-1:0] screen_width_ff, screen_width_in;
   logic [SCREEN_H_W-1:0] screen_height_ff, screen_height_in;
   logic [SCREEN_W_W-1:0] eff_width;
   logic [SCREEN_H_W-1:0] eff_height;

   // Always ready: the user must only write while the engine is idle; this block does not enforce it.
   assign csr_if.ready = 1'b1;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_if.valid) begin
         unique case (csr_if.payload.index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_if.payload.data;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_if.payload.data[SCREEN_H_W-1:0];
            default:           screen_width_in  = screen_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_W_RESET;
         screen_height_ff <= SCREEN_H_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // Clip oversized settings to the store's geometry.
   assign eff_width  = ({1'b0, screen_width_ff} > WIDTH_LIMIT) ?
                       WIDTH_LIMIT[SCREEN_W_W-1:0] : screen_width_ff;
   assign eff_height = ({1'b0, screen_height_ff} > HEIGHT_LIMIT) ?
                       HEIGHT_LIMIT[SCREEN_H_W-1:0] : screen_height_ff;

   assign geom.live          = (eff_width != '0) && (eff_height != '0);
   assign geom.width         = eff_width;
   assign geom.height        = eff_height;
   assign geom.bytes_per_row = eff_width[SCREEN_W_W-1:BIT_SEL_W];

endmodule

@@ src/pe16_seq.sv @@
module pe16_seq #(
   parameter int  MAX_WIDTH   = pe16_pkg::MAX_WIDTH_DEFAULT,
   parameter int  MAX_HEIGHT  = pe16_pkg::MAX_HEIGHT_DEFAULT,
   localparam int STORE_WORDS = (MAX_WIDTH / 8) * MAX_HEIGHT,
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pe16_pkg::geom_type          geom,
   pe16_chan_if.sink                   req_if,
   pe16_chan_if.source                 rsp_if,
   output logic                        mem_wr_en,
   output logic [ADDR_W-1:0]           mem_wr_addr,
   output logic [pe16_pkg::WORD_W-1:0] mem_wr_data,
   output logic                        mem_rd_en,
   output logic [ADDR_W-1:0]           mem_rd_addr,
   input  logic [pe16_pkg::WORD_W-1:0] mem_rd_data
);
   import pe16_pkg::*;

   localparam int CNT_W  = ADDR_W + 1;
   localparam int PROD_W = BPR_W + SCREEN_H_W;
   localparam int OFF_W  = PROD_W + 1;
   localparam logic [OFF_W-1:0] STORE_LIMIT = OFF_W'(STORE_WORDS);
   localparam logic [CNT_W-1:0] STORE_COUNT = CNT_W'(STORE_WORDS);

   localparam int              BRIGHT_AVG  = 170;
   localparam logic [9:0]      BRIGHT_SUM  = 10'(3 * (BRIGHT_AVG + 1) - 1);
   localparam logic [7:0]      CHAN_HALF   = 8'd127;
   localparam logic [7:0]      LEVEL_FULL  = 8'hFF;
   localparam logic [7:0]      LEVEL_DIM   = 8'h80;
   localparam logic [BIT_SEL_W-1:0] BIT_TOP = 3'd7;

   function automatic logic [NUM_PLANES-1:0] quantize(input logic [COLOUR_IN_W-1:0] argb);
      logic [7:0]            r;
      logic [7:0]            g;
      logic [7:0]            b;
      logic [9:0]            sum;
      logic [NUM_PLANES-1:0] idx;
      r      = argb[23:16];
      g      = argb[15:8];
      b      = argb[7:0];
      sum    = 10'(r) + 10'(g) + 10'(b);
      idx[0] = b > CHAN_HALF;
      idx[1] = g > CHAN_HALF;
      idx[2] = r > CHAN_HALF;
      idx[3] = sum > BRIGHT_SUM;
      return idx;
   endfunction

   function automatic logic [COLOUR_OUT_W-1:0] rebuild(input logic [NUM_PLANES-1:0] idx);
      logic [7:0] lvl;
      lvl = idx[3] ? LEVEL_FULL : LEVEL_DIM;
      return {idx[2] ? lvl : 8'h00, idx[1] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
   endfunction

   function automatic logic [NUM_PLANES-1:0] extract(input logic [WORD_W-1:0] word,
                                                      input logic [BIT_SEL_W-1:0] sel);
      logic [NUM_PLANES-1:0] idx;
      for (int p = 0; p < NUM_PLANES; p++) begin
         idx[p] = word[{PLANE_SEL_W'(p), sel}];
      end
      return idx;
   endfunction

   function automatic logic [WORD_W-1:0] insert(input logic [WORD_W-1:0] word,
                                                input logic [BIT_SEL_W-1:0] sel,
                                                input logic [NUM_PLANES-1:0] idx);
      logic [WORD_W-1:0] res;
      res = word;
      for (int p = 0; p < NUM_PLANES; p++) begin
         res[{PLANE_SEL_W'(p), sel}] = idx[p];
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] pattern(input logic [FILL_W-1:0] fill);
      logic [WORD_W-1:0] res;
      for (int p = 0; p < NUM_PLANES; p++) begin
         res[p*PLANE_BITS +: PLANE_BITS] = {PLANE_BITS{fill[p]}};
      end
      return res;
   endfunction

   seq_state_type          state_ff, state_in;
   req_payload_type        item_ff, item_in;
   logic [PROD_W-1:0]      off_raw_ff, off_raw_in;
   logic                   inside_ff, inside_in;
   logic [ADDR_W-1:0]      off_ff, off_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       limit_ff, limit_in;
   logic                   pend_ff, pend_in;
   logic [WORD_W-1:0]      fill_word_ff, fill_word_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_OUT_W-1:0] rsp_colour_ff, rsp_colour_in;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   copy_more;
   logic                   fill_more;
   logic                   rows_zero;
   logic                   rows_all;
   logic [BIT_SEL_W-1:0]   bit_sel;
   logic [PROD_W-1:0]      off_prod;
   logic [PROD_W-1:0]      area_prod;
   logic [PROD_W-1:0]      src_prod;
   logic [OFF_W-1:0]       off_wide;
   logic [OFF_W-1:0]       off_fold;
   logic                   in_range;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign copy_more    = rd_ptr_ff < limit_ff;
   assign fill_more    = cnt_ff < limit_ff;
   assign rows_zero    = (item_ff.scroll_rows == '0);
   assign rows_all     = {1'b0, item_ff.scroll_rows} >= geom.height;
   assign bit_sel      = BIT_TOP - item_ff.pos_x[BIT_SEL_W-1:0];

   assign off_prod  = PROD_W'(geom.bytes_per_row) * PROD_W'(item_ff.pos_y)
                    + PROD_W'(item_ff.pos_x[POS_X_W-1:BIT_SEL_W]);
   assign area_prod = PROD_W'(geom.bytes_per_row) * PROD_W'(geom.height);
   assign src_prod  = PROD_W'(geom.bytes_per_row) * PROD_W'(item_ff.scroll_rows);

   // A partial last byte can reach one word past the store: wrap it.
   assign off_wide = {1'b0, off_raw_ff};
   assign off_fold = (off_wide >= STORE_LIMIT) ? off_wide - STORE_LIMIT : off_wide;

   assign in_range = geom.live
                  && ({1'b0, item_ff.pos_x} < geom.width)
                  && ({1'b0, item_ff.pos_y} < geom.height);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_if.payload.action)
                  ACT_SET, ACT_GET:      state_in = ST_ADDR;
                  ACT_SCROLL, ACT_CLEAR: state_in = ST_SETUP;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADDR:   state_in = ST_LOOK;
         ST_LOOK:   state_in = ST_MODIFY;
         ST_MODIFY: begin
            if (item_ff.action == ACT_SET || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            priority if (!geom.live) begin
               state_in = ST_IDLE;
            end else if (item_ff.action == ACT_CLEAR) begin
               state_in = ST_FILL;
            end else if (rows_zero) begin
               state_in = ST_IDLE;
            end else if (rows_all) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (!pend_ff && !copy_more) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!fill_more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      off_raw_in    = off_raw_ff;
      inside_in     = inside_ff;
      off_in        = off_ff;
      cnt_in        = cnt_ff;
      rd_ptr_in     = rd_ptr_ff;
      limit_in      = limit_ff;
      pend_in       = pend_ff;
      fill_word_in  = fill_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_colour_in = rsp_colour_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff[ADDR_W-1:0];
      mem_wr_data   = fill_word_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_ptr_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in = req_if.payload;
            end
         end
         ST_ADDR: begin
            off_raw_in = off_prod;
            inside_in  = in_range;
         end
         ST_LOOK: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(off_fold);
            off_in      = ADDR_W'(off_fold);
         end
         ST_MODIFY: begin
            if (item_ff.action == ACT_SET) begin
               mem_wr_en   = inside_ff;
               mem_wr_addr = off_ff;
               mem_wr_data = insert(mem_rd_data, bit_sel, quantize(item_ff.colour_in));
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_colour_in = inside_ff ? rebuild(extract(mem_rd_data, bit_sel)) : '0;
            end
         end
         ST_SETUP: begin
            cnt_in       = '0;
            pend_in      = 1'b0;
            limit_in     = CNT_W'(area_prod);
            rd_ptr_in    = CNT_W'(src_prod);
            fill_word_in = (item_ff.action == ACT_CLEAR) ? pattern(item_ff.fill_index) : '0;
         end
         ST_COPY: begin
            // Write back last cycle's word while the next one is read ahead.
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               cnt_in      = cnt_ff + 1'b1;
            end
            if (copy_more) begin
               mem_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in   = 1'b0;
            end
         end
         ST_FILL: begin
            if (fill_more) begin
               mem_wr_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         limit_ff     <= STORE_COUNT;
         fill_word_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         fill_word_ff <= fill_word_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      off_raw_ff    <= off_raw_in;
      inside_ff     <= inside_in;
      off_ff        <= off_in;
      rd_ptr_ff     <= rd_ptr_in;
      rsp_colour_ff <= rsp_colour_in;
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.payload.colour_out = rsp_colour_ff;

endmodule

@@ src/planar_16colour_pixel_engine_top.sv @@
// Planar 16-colour pixel engine. Four 1-bit planes live side by side in one
// 32-bit word per byte offset, (width/8)*y + x/8, with the pixel in bit 7-(x mod 8)
// of each plane byte. A set transaction quantises an RGB colour to a 4-bit index
// and rewrites that bit in every plane; a get transaction returns the rebuilt
// RGB (0xFF or 0x80 per lit channel) as one result, or 0 off screen; scroll and
// clear return nothing. Set and get go from acceptance back to ready through an
// address multiply, a synchronous read and a write-back or result load.
// A get whose result cannot be loaded because the previous one is still waiting
// holds in place. Scroll and clear walk the store through its single write port,
// one word a cycle, or go back to idle straight from setup when nothing is to be
// done. After reset the whole store is swept to zero with the input held off;
// register writes are taken at any time and must only be issued while the engine
// is idle.
`include "planar_16colour_pixel_engine_top_defines.svh"
module planar_16colour_pixel_engine_top #(
   parameter int  MAX_WIDTH   = pe16_pkg::MAX_WIDTH_DEFAULT,
   parameter int  MAX_HEIGHT  = pe16_pkg::MAX_HEIGHT_DEFAULT,
   localparam int STORE_WORDS = (MAX_WIDTH / 8) * MAX_HEIGHT,
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   pe16_chan_if.sink   req_if,
   pe16_chan_if.source rsp_if,
   pe16_chan_if.sink   csr_if
);
   import pe16_pkg::*;

   geom_type          geom;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   // Screen geometry: hold the two registers and clip them to the store.
   pe16_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .geom   (geom)
   );

   // Sequencer: read-modify-write for pixels, sweeps for scroll, clear and reset.
   pe16_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Plane store: one write and one registered read per cycle.
   pe16_store #(
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // A scroll copy reads ahead of its write pointer: never the same word at once.
   `PE16_ASSERT_IMPLY(a_no_rw_overlap, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "store read and write hit the same word")
   // The store is quiet whenever a transaction is taken.
   `PE16_ASSERT_IMPLY(a_idle_on_accept, clock, reset, req_if.valid && req_if.ready, !mem_wr_en, "transaction accepted while the store is being written")
   // Drop ready after every accepted transaction.
   `PE16_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "ready held high after an accepted transaction")
   // Hold the input off while the post-reset sweep runs.
   `PE16_ASSERT_IMPLY(a_sweep_after_reset, clock, reset, $fell(reset), !req_if.ready, "input ready before the store was swept")

endmodule
